[rtl/assert_macros.svh]
// Assertion macros shared by the sorter RTL.
// Users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ISORT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ISORT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/isort_pkg.sv]
// Shared types and constants of the insertion sorter.
// No dependencies.
package isort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;   // place i_new_value, shifting larger entries up
        logic drain;    // shift the whole chain down by one
    } t_cell_ctl;

endpackage

[rtl/isort_in_if.sv]
// Input channel of the insertion sorter: valid/ready with value and last.
// Depends on isort_pkg.
interface isort_in_if;
    logic              valid;
    logic              ready;
    isort_pkg::t_value value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/isort_out_if.sv]
// Output channel of the insertion sorter: valid/ready with sorted data and flags.
// Depends on isort_pkg.
interface isort_out_if;
    logic              valid;
    logic              ready;
    isort_pkg::t_value sorted_value;
    logic              last_res;
    logic              overflow;

    modport source (output valid, output sorted_value, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_res, input overflow,
                    output ready);
endinterface

[rtl/isort_cell.sv]
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg.
module isort_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  isort_pkg::t_value    i_new_value,
    input  isort_pkg::t_value    i_left_value,
    input  logic                 i_left_valid,
    input  logic                 i_left_open,
    input  isort_pkg::t_value    i_right_value,
    input  logic                 i_right_valid,
    output logic                 o_open,
    output isort_pkg::t_value    o_value,
    output logic                 o_valid
);

    isort_pkg::t_value r_value;
    logic              r_valid;
    isort_pkg::t_value n_value;
    logic              n_valid;

    // Open: the new value belongs at or below this slot. Strictly greater
    // keeps equal values in arrival order.
    always_comb begin
        o_open  = !r_valid || (r_value > i_new_value);
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.drain) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.insert && o_open) begin
            if (i_left_open) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

[rtl/insertion_sorter.sv]
// Streaming insertion sorter: a chain of MAX_ITEMS compare-and-shift cells
// holds the run in ascending order. While a run fills, one item is taken
// every cycle; each new value is compared against all cells at once and
// inserted in that same cycle. The item flagged last ends the run: input is
// then held off while the chain drains out of its bottom cell, one result per
// cycle while the output is not stalled. Values beyond MAX_ITEMS are dropped
// and the whole run is marked overflow. The output register lets a new run
// begin filling while the final result of the previous run still waits.
// Depends on isort_pkg, isort_in_if, isort_out_if, isort_cell, assert_macros.svh.
`include "assert_macros.svh"

module insertion_sorter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    isort_in_if.sink           i_in,
    isort_out_if.source        o_out
);

    typedef enum logic {S_FILL, S_DRAIN} t_state;

    localparam int N = isort_pkg::MAX_ITEMS;

    t_state                r_state;
    isort_pkg::t_count     r_count;
    logic                  r_drop;
    logic                  r_out_valid;
    isort_pkg::t_value     r_out_value;
    logic                  r_out_last;
    logic                  r_out_ovf;

    isort_pkg::t_cell_ctl  w_ctl;
    isort_pkg::t_value     w_value [N];
    logic [N-1:0]          w_valid;
    logic [N-1:0]          w_open;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_shift;

    assign i_in.ready = (r_state == S_FILL);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == isort_pkg::t_count'(N));
    assign w_shift    = (r_state == S_DRAIN) && (r_count != '0)
                        && (!r_out_valid || o_out.ready);

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.drain  = w_shift;

    for (genvar g = 0; g < N; g++) begin : g_cell
        isort_pkg::t_value w_left_value;
        logic              w_left_valid;
        logic              w_left_open;
        isort_pkg::t_value w_right_value;
        logic              w_right_valid;

        if (g == 0) begin : g_bottom
            assign w_left_value = '0;
            assign w_left_valid = 1'b0;
            assign w_left_open  = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_open  = w_open[g-1];
        end

        if (g == N - 1) begin : g_top
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_below
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        isort_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_value   (i_in.value),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_open   (w_left_open),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_open        (w_open[g]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g])
        );
    end

    // Run sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_out_value <= w_value[0];
            r_out_last  <= (r_count == isort_pkg::t_count'(1));
            r_out_ovf   <= r_drop;
        end
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_shift) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + isort_pkg::t_count'(1);
                        end
                        if (i_in.last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_shift) begin
                        r_count <= r_count - isort_pkg::t_count'(1);
                        if (r_count == isort_pkg::t_count'(1)) begin
                            r_state <= S_FILL;
                            r_drop  <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_res     = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    // Occupied cells form a prefix whose size tracks the counter.
    `ISORT_ASSERT(a_count_matches_cells,
        (r_state == S_FILL) |-> ($countones(w_valid) == int'(r_count)),
        "cell occupancy disagrees with count")
    `ISORT_ASSERT(a_drop_sets_flag, (w_accept && w_full) |=> r_drop,
        "dropped item did not set overflow")
    `ISORT_ASSERT(a_drain_empties,
        (w_shift && r_count == isort_pkg::t_count'(1)) |=> (w_valid == '0 && r_state == S_FILL),
        "chain not empty after final result")

endmodule

[test/isort_checker.sv]
// Checker for the insertion sorter: watches both channels, keeps its own sorted
// copy of the current run and compares every result against it.
// Depends on isort_pkg, isort_in_if, isort_out_if.
`timescale 1ns / 1ps

module isort_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    isort_in_if   i_in_mon,
    isort_out_if  i_out_mon,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct {
        isort_pkg::t_value value;
        logic              last;
        logic              overflow;
    } t_sorted_result;

    isort_pkg::t_value run_vals[$];          // current run, ascending
    logic              run_dropped;
    t_sorted_result    sorted_results_q[$];  // results still owed by the block
    int                fail_count;

    initial begin
        run_dropped  = 1'b0;
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Insert after every stored value not greater than v; emit on last.
    task automatic insert_sorted(input isort_pkg::t_value v, input logic is_last);
        int pos;
        t_sorted_result r;
        if (run_vals.size() >= isort_pkg::MAX_ITEMS) begin
            run_dropped = 1'b1;
        end else begin
            pos = run_vals.size();
            for (int i = 0; i < run_vals.size(); i++) begin
                if ($signed(run_vals[i]) > $signed(v)) begin
                    pos = i;
                    break;
                end
            end
            run_vals.insert(pos, v);
        end
        if (is_last) begin
            for (int i = 0; i < run_vals.size(); i++) begin
                r.value    = run_vals[i];
                r.last     = (i == run_vals.size() - 1);
                r.overflow = run_dropped;
                sorted_results_q = {sorted_results_q, r};
            end
            run_vals.delete();
            run_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        t_sorted_result exp_r;
        if (sorted_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d last=%b ovf=%b",
                i_out_mon.sorted_value, i_out_mon.last_res, i_out_mon.overflow));
        end else begin
            exp_r = sorted_results_q.pop_front();
            if (i_out_mon.sorted_value !== exp_r.value)
                report_mismatch($sformatf("sorted_value %0d, expected %0d",
                    i_out_mon.sorted_value, exp_r.value));
            if (i_out_mon.last_res !== exp_r.last)
                report_mismatch($sformatf("last_res %b, expected %b",
                    i_out_mon.last_res, exp_r.last));
            if (i_out_mon.overflow !== exp_r.overflow)
                report_mismatch($sformatf("overflow %b, expected %b",
                    i_out_mon.overflow, exp_r.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                insert_sorted(i_in_mon.value, i_in_mon.last);
            if (i_out_mon.valid && i_out_mon.ready)
                check_result();
        end
        o_pending    = sorted_results_q.size();
        o_fail_count = fail_count;
    end

endmodule

[test/insertion_sorter_tb.sv]
// Testbench top for the insertion sorter: clock, reset, item stimulus with
// random idling on both channels, watchdog and verdict. Depends on isort_checker.
`timescale 1ns / 1ps

module insertion_sorter_tb;

    localparam int RAND_ITEMS       = 220;
    localparam int LONG_HOLD_CYCLES = 320;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam isort_pkg::t_value VAL_MIN = 32'sh8000_0000;
    localparam isort_pkg::t_value VAL_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    bit   tx_idle;
    bit   rx_idle;
    bit   long_hold_req;

    isort_in_if  in_if();
    isort_out_if out_if();

    insertion_sorter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    isort_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run ends if nothing moves on either channel for too long.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic isort_pkg::t_value rand_value();
        case ($urandom_range(0, 5))
            0:       return isort_pkg::t_value'($signed($urandom_range(0, 8)) - 4);  // duplicates
            1:       return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            2:       return $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                                 : VAL_MAX - $urandom_range(0, 3);
            default: return isort_pkg::t_value'($urandom());
        endcase
    endfunction

    task automatic send_item(input isort_pkg::t_value v, input logic is_last);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_run(input int len);
        for (int k = 0; k < len; k++)
            send_item(rand_value(), k == len - 1);
    endtask

    // Receiver: random stall bursts, plus one long hold to back the block up.
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                out_if.ready <= 1'b0;
                long_hold_req = 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge i_clk);
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int sent;
        int run_no;
        int len;
        in_if.valid   <= 1'b0;
        in_if.value   <= '0;
        in_if.last    <= 1'b0;
        i_rst_n       <= 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, duplicates and mixed signs in one run
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(VAL_MIN + 1, 1'b0);
        send_item(VAL_MAX - 1, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
        // single-item runs
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
        // already ascending, then descending
        send_item(-32'sd100, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd900, 1'b1);
        send_item(32'sd900, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(-32'sd100, 1'b1);

        sent   = 0;
        run_no = 0;
        while (sent < RAND_ITEMS) begin
            // longest run is MAX_ITEMS + 3, so the final run always starts past this
            if (sent >= RAND_ITEMS - 70) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (run_no == 2) begin
                // full store, no gaps, output held off once the run starts filling
                len     = isort_pkg::MAX_ITEMS;
                tx_idle = 1'b0;
                send_item(rand_value(), 1'b0);
                long_hold_req = 1'b1;
                send_run(len - 1);
            end else begin
                if (run_no == 5) begin
                    len = isort_pkg::MAX_ITEMS + 1;  // item flagged last is the one dropped
                end else if (run_no == 8) begin
                    len = isort_pkg::MAX_ITEMS + 3;
                end else if ($urandom_range(0, 7) == 0) begin
                    len = $urandom_range(11, 30);
                end else begin
                    len = $urandom_range(1, 8);
                end
                send_run(len);
            end
            sent += len;
            run_no++;
        end
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (isort_pkg::MAX_ITEMS + 16) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/isort_pkg.sv
rtl/isort_in_if.sv
rtl/isort_out_if.sv
rtl/isort_cell.sv
rtl/insertion_sorter.sv
test/isort_checker.sv
test/insertion_sorter_tb.sv
